/* src/rlst_pkg.sv */
// Shared types, widths and helpers for the rate-limited setpoint tracker.
// Used by the interfaces, the configuration registers, the controller, the datapath, the top level and the testbench.
// Depends on nothing.
package rlst_pkg;

  // Field widths fixed by the tick and result formats.
  localparam int PosW     = 32;
  localparam int StickW   = 10;
  localparam int GainW    = 16;
  localparam int PeriodW  = 16;
  localparam int TimeW    = 32;
  localparam int CfgDataW = 32;
  localparam int IdxW     = 2;

  // Internal datapath widths.
  localparam int DiffW   = PosW + 1;          // goal minus command, one axis
  localparam int SqW     = 2 * DiffW;         // sum of three squares fits here
  localparam int RootW   = SqW / 2;           // integer square root
  localparam int RemW    = RootW + 3;         // root remainder before compare
  localparam int QuotW   = GainW;             // step never exceeds arm_step
  localparam int NumW    = DiffW + GainW;     // rounded step numerator
  localparam int AdvW    = StickW + GainW + 1;
  localparam int WideW   = PosW + 2;          // room for a saturating add
  localparam int AxisW   = 2;
  localparam int IterW   = 6;

  localparam int RootIters = SqW / 2;
  localparam int DivIters  = QuotW;

  // Axis selects.
  localparam logic [AxisW-1:0] AXIS_X = 2'd0;
  localparam logic [AxisW-1:0] AXIS_Y = 2'd1;
  localparam logic [AxisW-1:0] AXIS_Z = 2'd2;

  // Configuration register indexes.
  typedef enum logic [IdxW-1:0] {
    REG_GOAL_GAIN    = 2'd0,
    REG_ARM_STEP     = 2'd1,
    REG_DEAD_ZONE    = 2'd2,
    REG_RUN_DURATION = 2'd3
  } reg_index_t;

  // Register values after reset.
  localparam logic [GainW-1:0] GOAL_GAIN_RST    = 16'd100;
  localparam logic [GainW-1:0] ARM_STEP_RST     = 16'd100;
  localparam logic [GainW-1:0] DEAD_ZONE_RST    = 16'd1000;
  localparam logic [TimeW-1:0] RUN_DURATION_RST = 32'd10000000;

  typedef struct packed {
    logic [GainW-1:0] goal_gain;
    logic [GainW-1:0] arm_step;
    logic [GainW-1:0] dead_zone;
    logic [TimeW-1:0] run_duration;
  } cfg_t;

  typedef struct packed {
    logic signed [PosW-1:0]   meas_x;
    logic signed [PosW-1:0]   meas_y;
    logic signed [PosW-1:0]   meas_z;
    logic signed [StickW-1:0] stick_x;
    logic signed [StickW-1:0] stick_y;
    logic signed [StickW-1:0] stick_z;
    logic                     stick_fresh;
    logic [PeriodW-1:0]       period_us;
  } tick_t;

  typedef struct packed {
    logic signed [PosW-1:0] cmd_x;
    logic signed [PosW-1:0] cmd_y;
    logic signed [PosW-1:0] cmd_z;
    logic                   finished;
  } result_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_ROOT,
    ST_CHECK,
    ST_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_APPLY,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             accept;
    logic             square;
    logic             accum;
    logic             root_step;
    logic             mul_step;
    logic             div_init;
    logic             div_step;
    logic             apply;
    logic             emit;
    logic [AxisW-1:0] axis;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic over_dead_zone;
    logic out_busy;
  } dp_status_t;

  // Clamp a widened signed value to the signed 32-bit range.
  function automatic logic [PosW-1:0] sat32(input logic [WideW-1:0] v);
    logic [PosW-1:0] r;
    if ((v[WideW-1:PosW-1] == '0) || (v[WideW-1:PosW-1] == '1)) begin
      r = v[PosW-1:0];
    end else if (v[WideW-1]) begin
      r = {1'b1, {(PosW-1){1'b0}}};
    end else begin
      r = {1'b0, {(PosW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

/* src/rlst_if.sv */
// Handshake channels of the setpoint tracker: tick items in, result items out.
// Depends on rlst_pkg for the field widths.
interface rlst_tick_if import rlst_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [PosW-1:0]   meas_x;
  logic signed [PosW-1:0]   meas_y;
  logic signed [PosW-1:0]   meas_z;
  logic signed [StickW-1:0] stick_x;
  logic signed [StickW-1:0] stick_y;
  logic signed [StickW-1:0] stick_z;
  logic                     stick_fresh;
  logic [PeriodW-1:0]       period_us;

  modport source (
    output valid, meas_x, meas_y, meas_z, stick_x, stick_y, stick_z, stick_fresh, period_us,
    input  ready
  );
  modport sink (
    input  valid, meas_x, meas_y, meas_z, stick_x, stick_y, stick_z, stick_fresh, period_us,
    output ready
  );
endinterface

interface rlst_result_if import rlst_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] cmd_x;
  logic signed [PosW-1:0] cmd_y;
  logic signed [PosW-1:0] cmd_z;
  logic                   finished;

  modport source (output valid, cmd_x, cmd_y, cmd_z, finished, input ready);
  modport sink (input valid, cmd_x, cmd_y, cmd_z, finished, output ready);
endinterface

/* src/rate_limited_setpoint_tracker_core.sv */
// Rate-limited setpoint tracker, top level.
// Each tick runs through the shared multiplier and the bit-pair square root and, when the
// command steps, through three restoring divide passes, one per axis, before its result.
// A new tick is taken only once the previous result is loaded into the output register,
// which stalls while the receiver holds off; the result waits in that register.
// Reset (rst, synchronous): state cleared, registers back to defaults, first tick loads.
module rate_limited_setpoint_tracker_core import rlst_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  rlst_tick_if.sink           tick,
  rlst_result_if.source       result,
  input  logic                wr_en,
  input  logic [IdxW-1:0]     wr_index,
  input  logic [CfgDataW-1:0] wr_data
);

  cfg_t       cfg;
  tick_t      tick_data;
  result_t    result_data;
  dp_cmd_t    ctl;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;

  // Configuration registers.
  rlst_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  // Sequencer.
  rlst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tick.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (ctl)
  );

  // Tick payload into one struct.
  assign tick_data.meas_x      = tick.meas_x;
  assign tick_data.meas_y      = tick.meas_y;
  assign tick_data.meas_z      = tick.meas_z;
  assign tick_data.stick_x     = tick.stick_x;
  assign tick_data.stick_y     = tick.stick_y;
  assign tick_data.stick_z     = tick.stick_z;
  assign tick_data.stick_fresh = tick.stick_fresh;
  assign tick_data.period_us   = tick.period_us;
  assign tick.ready            = in_ready;

  // Datapath.
  rlst_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .tick_data   (tick_data),
    .cmd         (ctl),
    .status      (status),
    .result_data (result_data),
    .out_valid   (out_valid),
    .out_ready   (result.ready)
  );

  assign result.valid    = out_valid;
  assign result.cmd_x    = result_data.cmd_x;
  assign result.cmd_y    = result_data.cmd_y;
  assign result.cmd_z    = result_data.cmd_z;
  assign result.finished = result_data.finished;

  // An accepted tick takes the block out of idle for the whole computation.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (tick.valid && tick.ready) |=> !tick.ready)
    else $error("tick taken while a previous tick is in progress");

  // Loading the result register always presents a result item.
  a_emit_shows_result: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |=> result.valid)
    else $error("result not presented after load");

  // The result fields only change when the datapath loads a new result.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    !ctl.emit |=> ($stable(result.cmd_x) && $stable(result.cmd_y) &&
                   $stable(result.cmd_z) && $stable(result.finished)))
    else $error("result changed without a load");

endmodule

/* src/rlst_cfg.sv */
// Configuration registers of the setpoint tracker, written through a plain write port.
// Depends on rlst_pkg.
module rlst_cfg import rlst_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [IdxW-1:0]     wr_index,
  input  logic [CfgDataW-1:0] wr_data,
  output cfg_t                cfg
);

  // Each register takes the low bits of the write data.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.goal_gain    <= GOAL_GAIN_RST;
      cfg.arm_step     <= ARM_STEP_RST;
      cfg.dead_zone    <= DEAD_ZONE_RST;
      cfg.run_duration <= RUN_DURATION_RST;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_GOAL_GAIN:    cfg.goal_gain    <= wr_data[GainW-1:0];
        REG_ARM_STEP:     cfg.arm_step     <= wr_data[GainW-1:0];
        REG_DEAD_ZONE:    cfg.dead_zone    <= wr_data[GainW-1:0];
        REG_RUN_DURATION: cfg.run_duration <= wr_data[TimeW-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* src/rlst_ctrl.sv */
// Sequencer of the setpoint tracker: walks one tick through squares, root and steps.
// Depends on rlst_pkg; drives the datapath only through dp_cmd_t.
module rlst_ctrl import rlst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t           state, state_next;
  logic [AxisW-1:0] axis, axis_next;
  logic [IterW-1:0] iter, iter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= AXIS_X;
      iter  <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      iter  <= iter_next;
    end
  end

  // Next state, axis and iteration count.
  always_comb begin
    state_next = state;
    axis_next  = axis;
    iter_next  = iter;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SQUARE;
          axis_next  = AXIS_X;
        end
      end
      ST_SQUARE: state_next = ST_ACCUM;
      ST_ACCUM: begin
        if (axis == AXIS_Z) begin
          state_next = ST_ROOT;
          iter_next  = '0;
        end else begin
          state_next = ST_SQUARE;
          axis_next  = axis + 1'b1;
        end
      end
      ST_ROOT: begin
        if (iter == IterW'(RootIters - 1)) begin
          state_next = ST_CHECK;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      ST_CHECK: begin
        if (status.over_dead_zone) begin
          state_next = ST_MUL;
          axis_next  = AXIS_X;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_MUL: state_next = ST_DIV_INIT;
      ST_DIV_INIT: begin
        state_next = ST_DIV;
        iter_next  = '0;
      end
      ST_DIV: begin
        if (iter == IterW'(DivIters - 1)) begin
          state_next = ST_APPLY;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      ST_APPLY: begin
        if (axis == AXIS_Z) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_MUL;
          axis_next  = axis + 1'b1;
        end
      end
      ST_EMIT: begin
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath commands decoded from the state.
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.axis      = axis;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_SQUARE:   cmd.square    = 1'b1;
      ST_ACCUM:    cmd.accum     = 1'b1;
      ST_ROOT:     cmd.root_step = 1'b1;
      ST_MUL:      cmd.mul_step  = 1'b1;
      ST_DIV_INIT: cmd.div_init  = 1'b1;
      ST_DIV:      cmd.div_step  = 1'b1;
      ST_APPLY:    cmd.apply     = 1'b1;
      ST_EMIT:     cmd.emit      = !status.out_busy;
      default: ;
    endcase
  end

endmodule

/* src/rlst_dp.sv */
// Datapath of the setpoint tracker: goal and command state, one shared multiplier,
// a bit-pair square root, a restoring divider and the output register.
// Depends on rlst_pkg; steered by dp_cmd_t from rlst_ctrl.
module rlst_dp import rlst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  tick_t      tick_data,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output result_t    result_data,
  output logic       out_valid,
  input  logic       out_ready
);

  // Tracker state.
  logic                     started;
  logic [PosW-1:0]          goal [3];
  logic [PosW-1:0]          cmd_pos [3];
  logic signed [StickW-1:0] last_stick [3];
  logic [TimeW-1:0]         elapsed;

  // Arithmetic registers.
  logic [SqW-1:0]   prod;
  logic [SqW-1:0]   sum;
  logic [RootW-1:0] root;
  logic [RemW-1:0]  rem;
  logic [DiffW-1:0] drem;
  logic [QuotW-1:0] dlow;
  logic [QuotW-1:0] quot;

  // Per-lane values at the moment an item is accepted.
  logic [PosW-1:0]          meas_in [3];
  logic signed [StickW-1:0] stick_in [3];
  logic signed [StickW-1:0] stick_use [3];
  logic [PosW-1:0]          base [3];
  logic signed [AdvW-1:0]   adv [3];
  logic [PosW-1:0]          goal_new [3];
  logic [TimeW:0]           elapsed_sum;

  assign meas_in[0]  = tick_data.meas_x;
  assign meas_in[1]  = tick_data.meas_y;
  assign meas_in[2]  = tick_data.meas_z;
  assign stick_in[0] = tick_data.stick_x;
  assign stick_in[1] = tick_data.stick_y;
  assign stick_in[2] = tick_data.stick_z;

  // Goal advance: seed from meas on the first tick, add stick times gain, saturate.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      base[k]      = started ? goal[k] : meas_in[k];
      stick_use[k] = tick_data.stick_fresh ? stick_in[k] : last_stick[k];
      adv[k]       = AdvW'(stick_use[k]) * $signed({1'b0, cfg.goal_gain});
      goal_new[k]  = sat32({{(WideW-PosW){base[k][PosW-1]}}, base[k]} +
                           {{(WideW-AdvW){adv[k][AdvW-1]}}, adv[k]});
    end
  end

  assign elapsed_sum = {1'b0, elapsed} + {{(TimeW+1-PeriodW){1'b0}}, tick_data.period_us};

  // Selected axis: difference, its magnitude and its sign.
  logic [PosW-1:0]  goal_sel, cmd_sel;
  logic [DiffW-1:0] diff, mag;
  logic             neg;

  always_comb begin
    case (cmd.axis)
      AXIS_Y: begin
        goal_sel = goal[1];
        cmd_sel  = cmd_pos[1];
      end
      AXIS_Z: begin
        goal_sel = goal[2];
        cmd_sel  = cmd_pos[2];
      end
      default: begin
        goal_sel = goal[0];
        cmd_sel  = cmd_pos[0];
      end
    endcase
    diff = {goal_sel[PosW-1], goal_sel} - {cmd_sel[PosW-1], cmd_sel};
    neg  = diff[DiffW-1];
    mag  = neg ? (~diff + 1'b1) : diff;
  end

  // Shared multiplier: squares of the differences, then magnitude times arm_step.
  logic [DiffW-1:0] op_b;
  assign op_b = cmd.square ? mag : {{(DiffW-GainW){1'b0}}, cfg.arm_step};

  // Square-root step on two radicand bits.
  logic [RemW-1:0] rem_shift, trial;
  logic            root_bit;
  assign rem_shift = {rem[RemW-3:0], sum[SqW-1 -: 2]};
  assign trial     = {1'b0, root, 2'b01};
  assign root_bit  = (rem_shift >= trial);

  // Divider: rounded numerator and one restoring step.
  logic [NumW-1:0] num;
  logic [DiffW:0]  drem_shift;
  logic            quot_bit;
  assign num        = prod[NumW-1:0] + {{(NumW-RootW+1){1'b0}}, root[RootW-1:1]};
  assign drem_shift = {drem, dlow[QuotW-1]};
  assign quot_bit   = (drem_shift >= {1'b0, root});

  // Command update with a signed step.
  logic [WideW-1:0] step_wide, cmd_new;
  always_comb begin
    step_wide = {{(WideW-QuotW){1'b0}}, quot};
    if (neg) begin
      step_wide = ~step_wide + 1'b1;
    end
    cmd_new = {{(WideW-PosW){cmd_sel[PosW-1]}}, cmd_sel} + step_wide;
  end

  // Control state of the tracker.
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      elapsed <= '0;
      for (int k = 0; k < 3; k++) begin
        last_stick[k] <= '0;
      end
    end else if (cmd.accept) begin
      started <= 1'b1;
      elapsed <= elapsed_sum[TimeW] ? '1 : elapsed_sum[TimeW-1:0];
      for (int k = 0; k < 3; k++) begin
        last_stick[k] <= stick_use[k];
      end
    end
  end

  // Goal and command positions.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int k = 0; k < 3; k++) begin
        goal[k]    <= goal_new[k];
        cmd_pos[k] <= base[k] == goal[k] && started ? cmd_pos[k] :
                      (started ? cmd_pos[k] : meas_in[k]);
      end
    end else if (cmd.apply) begin
      case (cmd.axis)
        AXIS_Y:  cmd_pos[1] <= sat32(cmd_new);
        AXIS_Z:  cmd_pos[2] <= sat32(cmd_new);
        default: cmd_pos[0] <= sat32(cmd_new);
      endcase
    end
  end

  // Multiplier, accumulator and square root.
  always_ff @(posedge clk) begin
    if (cmd.square || cmd.mul_step) begin
      prod <= SqW'(mag) * SqW'(op_b);
    end
    if (cmd.accept) begin
      sum  <= '0;
      root <= '0;
      rem  <= '0;
    end else if (cmd.accum) begin
      sum <= sum + prod;
    end else if (cmd.root_step) begin
      sum  <= {sum[SqW-3:0], 2'b00};
      rem  <= root_bit ? (rem_shift - trial) : rem_shift;
      root <= {root[RootW-2:0], root_bit};
    end
  end

  // Restoring divider for the per-axis step.
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      drem <= num[NumW-1:QuotW];
      dlow <= num[QuotW-1:0];
      quot <= '0;
    end else if (cmd.div_step) begin
      drem <= quot_bit ? DiffW'(drem_shift - {1'b0, root}) : drem_shift[DiffW-1:0];
      dlow <= {dlow[QuotW-2:0], 1'b0};
      quot <= {quot[QuotW-2:0], quot_bit};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_data <= '0;
    end else if (cmd.emit) begin
      result_data.cmd_x    <= cmd_pos[0];
      result_data.cmd_y    <= cmd_pos[1];
      result_data.cmd_z    <= cmd_pos[2];
      result_data.finished <= (elapsed >= cfg.run_duration);
    end
  end

  assign status.over_dead_zone = (root > {{(RootW-GainW){1'b0}}, cfg.dead_zone});
  assign status.out_busy       = out_valid && !out_ready;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the rate-limited setpoint tracker core.
// Depends on rlst_pkg, the rlst_tick_if and rlst_result_if channels and the core itself.
// A directed table runs first, then random ticks under several register settings.
module testbench;
  import rlst_pkg::*;

  localparam int  NumRows       = 16;
  localparam int  NumPhases     = 8;
  localparam int  TicksPerPhase = 242;
  localparam int  HoldCycles    = 600;
  localparam int  DrainCycles   = 150;
  localparam int  CycleLimit    = 3000000;
  localparam int  ReportCap     = 50;
  localparam longint PosMax     = 2147483647;
  localparam longint PosMin     = -PosMax - 1;

  // One row of the directed table: an optional register write, then a tick.
  typedef struct {
    logic                do_cfg;
    reg_index_t          reg_sel;
    logic [CfgDataW-1:0] cfg_data;
    tick_t               stim;
    logic                pinned;
    result_t             want;
  } row_t;

  logic                clk;
  logic                rst;
  logic                wr_en;
  logic [IdxW-1:0]     wr_index;
  logic [CfgDataW-1:0] wr_data;

  rlst_tick_if   tick_ch ();
  rlst_result_if result_ch ();

  rate_limited_setpoint_tracker_core u_top (
    .clk      (clk),
    .rst      (rst),
    .tick     (tick_ch),
    .result   (result_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // Tracker state as this bench sees it.
  cfg_t                   trk_cfg = '{GOAL_GAIN_RST, ARM_STEP_RST, DEAD_ZONE_RST, RUN_DURATION_RST};
  logic                   trk_started = 1'b0;
  logic signed [PosW-1:0] trk_goal [3] = '{default: '0};
  logic signed [PosW-1:0] trk_cmd [3] = '{default: '0};
  logic signed [StickW-1:0] trk_stick [3] = '{default: '0};
  logic [TimeW-1:0]       trk_elapsed = '0;

  result_t pending_cmds [$];

  // Typed expectation that travels with the tick currently offered.
  logic    pin_now;
  result_t pin_want;

  int  burst_left = 0;
  int  ticks_in = 0;
  int  results_checked = 0;
  int  mismatches = 0;
  int  steps_taken = 0;
  int  holds = 0;
  int  finished_seen = 0;
  int  cycle_count = 0;
  bit  hold_done = 1'b0;

  // Directed stimulus. Only the first two rows carry a typed expectation.
  row_t plan [NumRows] = '{
    // First tick loads both rails; a stale stick right after reset is still zero.
    '{1'b0, REG_GOAL_GAIN, 32'd0,
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 10'sd100, -10'sd100, 10'sd5, 1'b0, 16'd0},
      1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 1'b0}},
    // Full deflection drives the goal into saturation; the command has nowhere to go.
    '{1'b0, REG_GOAL_GAIN, 32'd0,
      '{32'd0, 32'd0, 32'd0, 10'h1FF, 10'h200, 10'sd0, 1'b1, 16'hFFFF},
      1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 1'b0}},
    '{1'b0, REG_GOAL_GAIN, 32'd0,
      '{32'd0, 32'd0, 32'd0, 10'sd0, 10'sd0, 10'h1FF, 1'b1, 16'd1000}, 1'b0, '0},
    '{1'b0, REG_GOAL_GAIN, 32'd0,
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -10'sd1, -10'sd1, -10'sd1, 1'b0, 16'd1},
      1'b0, '0},
    '{1'b0, REG_GOAL_GAIN, 32'd0,
      '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 10'h200, 10'h1FF, 10'h200, 1'b1,
        16'hFFFF}, 1'b0, '0},
    '{1'b1, REG_RUN_DURATION, 32'd0,
      '{32'd0, 32'd0, 32'd0, 10'sd0, 10'sd0, 10'sd0, 1'b1, 16'd0}, 1'b0, '0},
    '{1'b1, REG_GOAL_GAIN, 32'hFFFF_0000,
      '{32'd0, 32'd0, 32'd0, 10'h1FF, 10'h1FF, 10'h1FF, 1'b1, 16'd7}, 1'b0, '0},
    '{1'b1, REG_ARM_STEP, 32'h0000_FFFF,
      '{32'd0, 32'd0, 32'd0, 10'sd0, 10'sd0, 10'sd0, 1'b1, 16'd20}, 1'b0, '0},
    '{1'b1, REG_DEAD_ZONE, 32'h1234_FFFF,
      '{32'd0, 32'd0, 32'd0, 10'h2AA, 10'h155, 10'h0F0, 1'b0, 16'd20}, 1'b0, '0},
    '{1'b1, REG_ARM_STEP, 32'd0,
      '{32'd0, 32'd0, 32'd0, 10'sd0, 10'sd0, 10'sd0, 1'b1, 16'd20}, 1'b0, '0},
    '{1'b1, REG_GOAL_GAIN, 32'h0000_FFFF,
      '{32'd0, 32'd0, 32'd0, 10'h1FF, 10'h200, 10'h1FF, 1'b1, 16'd20}, 1'b0, '0},
    '{1'b0, REG_GOAL_GAIN, 32'd0,
      '{32'd0, 32'd0, 32'd0, 10'sd3, 10'sd3, 10'sd3, 1'b0, 16'd0}, 1'b0, '0},
    '{1'b1, REG_DEAD_ZONE, 32'd0,
      '{32'd0, 32'd0, 32'd0, 10'sd0, 10'sd0, 10'sd0, 1'b0, 16'd20}, 1'b0, '0},
    '{1'b1, REG_ARM_STEP, 32'd1,
      '{32'd0, 32'd0, 32'd0, 10'sd0, 10'sd0, 10'sd0, 1'b1, 16'd20}, 1'b0, '0},
    '{1'b1, REG_RUN_DURATION, 32'hFFFF_FFFF,
      '{32'd0, 32'd0, 32'd0, -10'sd1, 10'sd0, 10'sd1, 1'b1, 16'hFFFF}, 1'b0, '0},
    '{1'b1, REG_GOAL_GAIN, 32'd1,
      '{32'd0, 32'd0, 32'd0, 10'sd1, 10'sd0, 10'sd0, 1'b1, 16'd3}, 1'b0, '0}
  };

  // Clock with a 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp a wide signed value to the 32-bit position range.
  function automatic logic signed [PosW-1:0] clamp_pos(input longint v);
    if (v > PosMax) return PosMax[PosW-1:0];
    if (v < PosMin) return PosMin[PosW-1:0];
    return v[PosW-1:0];
  endfunction

  // Floor of the square root, one result bit per pass from the top.
  function automatic logic [33:0] floor_root(input logic [67:0] n);
    logic [67:0] rem;
    logic [67:0] root;
    logic [67:0] bitv;
    rem  = n;
    root = '0;
    bitv = 68'd1 << 66;
    for (int i = 0; i < 34; i++) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[33:0];
  endfunction

  // Advance the tracker by one tick and return the command it should report.
  function automatic result_t advance_tracker(input tick_t t);
    logic signed [PosW-1:0]   meas [3];
    logic signed [StickW-1:0] new_stick [3];
    longint                   diff [3];
    longint unsigned          mag [3];
    logic [63:0]              sq;
    logic [67:0]              sum_sq;
    logic [33:0]              lag_len;
    logic [TimeW:0]           later;
    longint unsigned          step_len;
    longint                   gain, st, g, c, moved;
    result_t                  r;
    meas      = '{t.meas_x, t.meas_y, t.meas_z};
    new_stick = '{t.stick_x, t.stick_y, t.stick_z};
    later = (TimeW+1)'(trk_elapsed) + (TimeW+1)'(t.period_us);
    trk_elapsed = later[TimeW] ? '1 : later[TimeW-1:0];
    if (!trk_started) begin
      trk_goal    = meas;
      trk_cmd     = meas;
      trk_started = 1'b1;
    end
    if (t.stick_fresh) trk_stick = new_stick;
    // Move the goal, then measure how far the command lags behind it.
    gain   = trk_cfg.goal_gain;
    sum_sq = '0;
    for (int k = 0; k < 3; k++) begin
      st = trk_stick[k];
      g  = trk_goal[k];
      trk_goal[k] = clamp_pos(g + st * gain);
      g = trk_goal[k];
      c = trk_cmd[k];
      diff[k] = g - c;
      mag[k]  = (diff[k] < 0) ? -diff[k] : diff[k];
      sq      = mag[k] * mag[k];
      sum_sq  = sum_sq + 68'(sq);
    end
    lag_len = floor_root(sum_sq);
    // Outside the dead zone the command takes one rounded step toward the goal.
    if (lag_len > trk_cfg.dead_zone) begin
      step_len = trk_cfg.arm_step;
      for (int k = 0; k < 3; k++) begin
        moved = (mag[k] * step_len + lag_len / 2) / lag_len;
        if (diff[k] < 0) moved = -moved;
        c = trk_cmd[k];
        trk_cmd[k] = clamp_pos(c + moved);
      end
      steps_taken++;
    end else begin
      holds++;
    end
    r.cmd_x    = trk_cmd[0];
    r.cmd_y    = trk_cmd[1];
    r.cmd_z    = trk_cmd[2];
    r.finished = (trk_elapsed >= trk_cfg.run_duration);
    return r;
  endfunction

  // Track register writes and accepted ticks at each rising edge.
  always @(posedge clk) begin : watch_inputs
    tick_t   seen;
    result_t r;
    if (!rst) begin
      if (wr_en) begin
        case (reg_index_t'(wr_index))
          REG_GOAL_GAIN:    trk_cfg.goal_gain    = wr_data[GainW-1:0];
          REG_ARM_STEP:     trk_cfg.arm_step     = wr_data[GainW-1:0];
          REG_DEAD_ZONE:    trk_cfg.dead_zone    = wr_data[GainW-1:0];
          REG_RUN_DURATION: trk_cfg.run_duration = wr_data[TimeW-1:0];
          default: ;
        endcase
      end
      if (tick_ch.valid && tick_ch.ready) begin
        seen = '{tick_ch.meas_x, tick_ch.meas_y, tick_ch.meas_z, tick_ch.stick_x,
                 tick_ch.stick_y, tick_ch.stick_z, tick_ch.stick_fresh, tick_ch.period_us};
        r = advance_tracker(seen);
        if (pin_now) r = pin_want;
        pending_cmds.push_back(r);
        ticks_in++;
      end
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= ReportCap)
        $display("t=%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Compare every accepted result item with the oldest expectation.
  always @(posedge clk) begin : watch_results
    result_t got;
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = '{result_ch.cmd_x, result_ch.cmd_y, result_ch.cmd_z, result_ch.finished};
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportCap)
          $display("t=%0t: result item with no tick waiting, expected none, got cmd %0d %0d %0d",
                   $time, got.cmd_x, got.cmd_y, got.cmd_z);
      end else begin
        want = pending_cmds.pop_front();
        results_checked++;
        if (got.finished) finished_seen++;
        check_field("cmd_x", want.cmd_x, got.cmd_x);
        check_field("cmd_y", want.cmd_y, got.cmd_y);
        check_field("cmd_z", want.cmd_z, got.cmd_z);
        check_field("finished", want.finished, got.finished);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               pending_cmds.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: stretches of full, patchy and sparse readiness, plus one long hold-off.
  initial begin : receiver
    int mode;
    int span_len;
    result_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!hold_done && ticks_in >= 300) begin
        result_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_done = 1'b1;
      end
      mode     = $urandom_range(0, 3);
      span_len = $urandom_range(5, 200);
      repeat (span_len) begin
        case (mode)
          0:       result_ch.ready <= 1'b1;
          1:       result_ch.ready <= 1'($urandom_range(0, 1));
          2:       result_ch.ready <= ($urandom_range(0, 7) == 0);
          default: result_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Offer one tick and wait for it to be taken; bursts end in a random gap.
  task automatic push_tick(input tick_t t, input logic pinned, input result_t want);
    tick_ch.valid       <= 1'b1;
    tick_ch.meas_x      <= t.meas_x;
    tick_ch.meas_y      <= t.meas_y;
    tick_ch.meas_z      <= t.meas_z;
    tick_ch.stick_x     <= t.stick_x;
    tick_ch.stick_y     <= t.stick_y;
    tick_ch.stick_z     <= t.stick_z;
    tick_ch.stick_fresh <= t.stick_fresh;
    tick_ch.period_us   <= t.period_us;
    pin_now             <= pinned;
    pin_want            <= want;
    do @(posedge clk); while (!tick_ch.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      tick_ch.valid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 6))
        @(posedge clk);
    end
  endtask

  // Stop offering and wait until every expected result item has come back.
  task automatic settle();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Drive one register write; the caller lowers wr_en after its last write.
  task automatic write_reg(input reg_index_t idx, input logic [CfgDataW-1:0] d);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= d;
    @(posedge clk);
  endtask

  function automatic logic signed [StickW-1:0] pick_stick();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return StickW'($signed($urandom_range(0, 16)) - 8);
      4:       return $urandom_range(0, 1) ? 10'h1FF : 10'h200;
      default: return StickW'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    t.meas_x      = PosW'($urandom());
    t.meas_y      = PosW'($urandom());
    t.meas_z      = PosW'($urandom());
    t.stick_x     = pick_stick();
    t.stick_y     = pick_stick();
    t.stick_z     = pick_stick();
    t.stick_fresh = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 3))
      0:       t.period_us = PeriodW'($urandom_range(0, 50));
      1:       t.period_us = PeriodW'($urandom_range(0, 2000));
      2:       t.period_us = PeriodW'($urandom_range(0, 65535));
      default: t.period_us = 16'hFFFF;
    endcase
    return t;
  endfunction

  // Main sequence: reset, directed table, random phases, drain and verdict.
  initial begin : stimulus
    logic [GainW-1:0]    gain_v, step_v, dz_v;
    logic [TimeW-1:0]    dur_v;
    logic [CfgDataW-GainW-1:0] junk;
    rst                 <= 1'b1;
    wr_en               <= 1'b0;
    wr_index            <= REG_GOAL_GAIN;
    wr_data             <= '0;
    tick_ch.valid       <= 1'b0;
    tick_ch.meas_x      <= '0;
    tick_ch.meas_y      <= '0;
    tick_ch.meas_z      <= '0;
    tick_ch.stick_x     <= '0;
    tick_ch.stick_y     <= '0;
    tick_ch.stick_z     <= '0;
    tick_ch.stick_fresh <= 1'b0;
    tick_ch.period_us   <= '0;
    pin_now             <= 1'b0;
    pin_want            <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed table; register writes only once the block has drained.
    for (int i = 0; i < NumRows; i++) begin
      if (plan[i].do_cfg) begin
        settle();
        write_reg(plan[i].reg_sel, plan[i].cfg_data);
        wr_en <= 1'b0;
      end
      push_tick(plan[i].stim, plan[i].pinned, plan[i].want);
    end

    // Random ticks under a series of register settings: fixed ones first, among them extremes, then random ones.
    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      case (ph)
        0: begin
          gain_v = 16'd100; step_v = 16'd100; dz_v = 16'd1000;
          dur_v  = trk_elapsed + $urandom_range(0, 6000000);
        end
        1: begin
          gain_v = 16'hFFFF; step_v = 16'hFFFF; dz_v = 16'd0; dur_v = '0;
        end
        2: begin
          gain_v = 16'd0; step_v = 16'd0; dz_v = 16'hFFFF; dur_v = '1;
        end
        3: begin
          gain_v = 16'd1; step_v = 16'd1; dz_v = 16'd0;
          dur_v  = trk_elapsed + $urandom_range(0, 6000000);
        end
        4: begin
          gain_v = 16'd20; step_v = 16'd5000; dz_v = 16'd20000;
          dur_v  = trk_elapsed + $urandom_range(0, 6000000);
        end
        default: begin
          gain_v = ($urandom_range(0, 3) == 0) ? GainW'($urandom_range(0, 65535)) :
                                                 GainW'($urandom_range(0, 400));
          step_v = GainW'($urandom_range(0, 65535));
          dz_v   = GainW'($urandom_range(0, 3000));
          dur_v  = trk_elapsed + $urandom_range(0, 6000000);
        end
      endcase
      junk = (CfgDataW-GainW)'($urandom());
      write_reg(REG_GOAL_GAIN, {junk, gain_v});
      write_reg(REG_ARM_STEP, {~junk, step_v});
      write_reg(REG_DEAD_ZONE, {junk ^ 16'h5A5A, dz_v});
      write_reg(REG_RUN_DURATION, dur_v);
      wr_en <= 1'b0;
      for (int n = 0; n < TicksPerPhase; n++)
        push_tick(random_tick(), 1'b0, '0);
    end

    // Drain, then leave room for any stray result item.
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Covered %0d ticks (%0d directed) over %0d register settings, %0d results checked.",
             ticks_in, NumRows, NumPhases + 1, results_checked);
    $display("The command stepped on %0d ticks and held on %0d; finished was high on %0d.",
             steps_taken, holds, finished_seen);
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* rate_limited_setpoint_tracker_core.f */
src/rlst_pkg.sv
src/rlst_if.sv
src/rlst_cfg.sv
src/rlst_ctrl.sv
src/rlst_dp.sv
src/rate_limited_setpoint_tracker_core.sv
tb/testbench.sv
